### design/tksr_pkg.sv
// tksr_pkg: types and constants shared by the top-k score ranking table
// no dependencies
package tksr_pkg;

   localparam int Entries   = 128;
   localparam int SlotBits  = $clog2(Entries);
   localparam int CountBits = $clog2(Entries + 1);

   typedef enum logic [1:0] {
      FUNC_UPDATE = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_RANK   = 2'd2,
      FUNC_ENTRY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_PLACE = 2'd1,
      ST_ABSENT    = 2'd2,
      ST_BAD_RANK  = 2'd3
   } status_type;

   typedef struct packed {
      logic [63:0] id;
      logic [63:0] score;
   } entry_type;

   // signed greater-than on raw bits
   function automatic logic beats(input logic [63:0] a, input logic [63:0] b);
      beats = $signed(a) > $signed(b);
   endfunction

   // slot index (0 based) to 8-bit rank field
   function automatic logic [7:0] to_rank(input logic [SlotBits-1:0] slot);
      logic [31:0] r;
      r = 32'(slot) + 32'd1;
      to_rank = r[7:0];
   endfunction

endpackage

### design/top_k_score_ranking_table.sv
// top_k_score_ranking_table: ranked (id, score) list held in one memory
// depends on tksr_pkg
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------------
//  request | req_func req_entry_id req_score_value        | start & !busy
//          | req_rank_position                            |
//  result  | rsp_status rsp_rank_before rsp_rank_after    | rsp_strobe, one cycle
//          | rsp_found_id rsp_found_score                 |
//
// one command at a time, paced by one memory read a cycle: the id search reads
// one slot a cycle, each move step is a write, a neighbor read and a compare,
// and each remove shift step is a read then a write one slot up.
// entry query: the rank is checked and the slot read, then the result is
// reported; a bad rank is reported without the read.
// reset clears the count; memory is not cleared. the receiver cannot stall.
module top_k_score_ranking_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_entry_id,
   input  logic [63:0] req_score_value,
   input  logic [7:0]  req_rank_position,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_rank_before,
   output logic [7:0]  rsp_rank_after,
   output logic [63:0] rsp_found_id,
   output logic [63:0] rsp_found_score
);

   localparam int SB = tksr_pkg::SlotBits;
   localparam int CB = tksr_pkg::CountBits;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_SEARCH = 8'b00000010, // read issued for scan_ff, data next cycle
      S_FULLRD = 8'b00000100, // last slot read for eviction test
      S_PLACE  = 8'b00001000, // write the held entry at cur_ff
      S_NBRRD  = 8'b00010000, // neighbor read issued
      S_NBRCHK = 8'b00100000, // compare neighbor, swap or finish
      S_SHIFT  = 8'b01000000, // remove: read next, write back one up
      S_DONE   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // memory
   tksr_pkg::entry_type mem [tksr_pkg::Entries];
   tksr_pkg::entry_type rd_data;
   logic                mem_we;
   logic [SB-1:0]       mem_waddr, mem_raddr;
   tksr_pkg::entry_type mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data <= mem[mem_raddr];
   end

   logic [1:0]    func_ff;
   logic [63:0]   id_ff, score_ff;
   logic [7:0]    rankq_ff;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] scan_ff, scan_in;     // search index
   logic [SB-1:0] cur_ff, cur_in;       // slot of the moving entry
   logic          dir_ff, dir_in;       // 0 moving up, 1 moving down
   logic          rdv_ff, rdv_in;       // a read is in flight (search, entry query or shift)
   logic [1:0]    st_ff, st_in;
   logic [7:0]    old_ff, old_in, new_ff, new_in;
   logic [63:0]   fid_ff, fid_in, fsc_ff, fsc_in;
   logic          strobe_ff, strobe_in;

   logic [CB:0]   rank_ext;
   assign rank_ext = (CB+1)'(rankq_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      cur_in    = cur_ff;
      dir_in    = dir_ff;
      rdv_in    = 1'b0;
      st_in     = st_ff;
      old_in    = old_ff;
      new_in    = new_ff;
      fid_in    = fid_ff;
      fsc_in    = fsc_ff;
      strobe_in = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = cur_ff;
      mem_wdata = '{id: id_ff, score: score_ff};
      mem_raddr = scan_ff[SB-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               st_in  = tksr_pkg::ST_OK;
               old_in = '0;
               new_in = '0;
               fid_in = '0;
               fsc_in = '0;
               scan_in = '0;
               if (req_func == tksr_pkg::FUNC_ENTRY) begin
                  state_in = S_FULLRD; // reused: one read then report
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            // check data of previous read, issue next
            if (rdv_ff && rd_data.id == id_ff) begin
               cur_in = SB'(scan_ff - CB'(1));
               old_in = tksr_pkg::to_rank(SB'(scan_ff - CB'(1)));
               case (func_ff)
                  tksr_pkg::FUNC_RANK: begin
                     new_in = old_in; old_in = '0; state_in = S_DONE;
                  end
                  tksr_pkg::FUNC_REMOVE: begin
                     state_in = S_SHIFT;
                  end
                  default: begin
                     state_in = S_PLACE; dir_in = 1'b0;
                  end
               endcase
            end else if (scan_ff >= count_ff) begin
               // id absent
               case (func_ff)
                  tksr_pkg::FUNC_UPDATE: begin
                     if (count_ff == CB'(tksr_pkg::Entries)) begin
                        mem_raddr = SB'(tksr_pkg::Entries - 1);
                        state_in  = S_FULLRD;
                     end else begin
                        cur_in   = count_ff[SB-1:0];
                        count_in = count_ff + CB'(1);
                        dir_in   = 1'b0;
                        state_in = S_PLACE;
                     end
                  end
                  default: begin
                     st_in = tksr_pkg::ST_ABSENT; state_in = S_DONE;
                  end
               endcase
            end else begin
               rdv_in  = 1'b1;
               scan_in = scan_ff + CB'(1);
            end
         end
         S_FULLRD: begin
            if (func_ff == tksr_pkg::FUNC_ENTRY) begin
               // rank check, then the read is issued at rank-1 below
               if (!rdv_ff) begin
                  if (rankq_ff == 8'd0 || rank_ext > (CB+1)'(count_ff)) begin
                     st_in = tksr_pkg::ST_BAD_RANK; state_in = S_DONE;
                  end else begin
                     mem_raddr = SB'(rankq_ff - 8'd1);
                     rdv_in = 1'b1;
                  end
               end else begin
                  fid_in = rd_data.id; fsc_in = rd_data.score; state_in = S_DONE;
               end
            end else begin
               if (tksr_pkg::beats(score_ff, rd_data.score)) begin
                  cur_in = SB'(tksr_pkg::Entries - 1);
                  dir_in = 1'b0;
                  state_in = S_PLACE;
               end else begin
                  st_in = tksr_pkg::ST_NOT_PLACE; state_in = S_DONE;
               end
            end
         end
         S_PLACE: begin
            mem_we = 1'b1;
            mem_waddr = cur_ff;
            // read the neighbor in the current direction; at the top, turn downward
            if (!dir_ff) begin
               if (cur_ff == '0) begin
                  dir_in = 1'b1;
                  if (CB'(cur_ff) + CB'(1) < count_ff) begin
                     mem_raddr = cur_ff + SB'(1); state_in = S_NBRRD;
                  end else begin
                     new_in = tksr_pkg::to_rank(cur_ff); state_in = S_DONE;
                  end
               end else begin
                  mem_raddr = cur_ff - SB'(1); state_in = S_NBRRD;
               end
            end else begin
               if (CB'(cur_ff) + CB'(1) < count_ff) begin
                  mem_raddr = cur_ff + SB'(1); state_in = S_NBRRD;
               end else begin
                  new_in = tksr_pkg::to_rank(cur_ff); state_in = S_DONE;
               end
            end
         end
         S_NBRRD: begin
            // keep the neighbor address so the read data stays in place
            mem_raddr = dir_ff ? cur_ff + SB'(1) : cur_ff - SB'(1);
            state_in  = S_NBRCHK;
         end
         S_NBRCHK: begin
            if ((!dir_ff && tksr_pkg::beats(score_ff, rd_data.score)) ||
                (dir_ff && tksr_pkg::beats(rd_data.score, score_ff))) begin
               // swap: neighbor goes into cur slot, held entry moves
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = rd_data;
               cur_in    = dir_ff ? cur_ff + SB'(1) : cur_ff - SB'(1);
               state_in  = S_PLACE;
            end else if (!dir_ff) begin
               // upward move over; try downward from here
               dir_in = 1'b1;
               if (CB'(cur_ff) + CB'(1) < count_ff) begin
                  mem_raddr = cur_ff + SB'(1); state_in = S_NBRRD;
               end else begin
                  new_in = tksr_pkg::to_rank(cur_ff); state_in = S_DONE;
               end
            end else begin
               new_in = tksr_pkg::to_rank(cur_ff); state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            // cur_ff is the hole; rd of cur+1 issued last cycle when rdv_ff
            if (rdv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = rd_data;
               cur_in    = cur_ff + SB'(1);
            end else if (CB'(cur_ff) + CB'(1) < count_ff) begin
               mem_raddr = cur_ff + SB'(1);
               rdv_in    = 1'b1;
            end else begin
               count_in = count_ff - CB'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rdv_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rdv_ff    <= rdv_in;
         strobe_ff <= strobe_in;
      end
      scan_ff <= scan_in;
      cur_ff  <= cur_in;
      dir_ff  <= dir_in;
      st_ff   <= st_in;
      old_ff  <= old_in;
      new_ff  <= new_in;
      fid_ff  <= fid_in;
      fsc_ff  <= fsc_in;
      if (state_ff == S_IDLE && start) begin
         func_ff  <= req_func;
         id_ff    <= req_entry_id;
         score_ff <= req_score_value;
         rankq_ff <= req_rank_position;
      end else if (state_ff == S_FULLRD && func_ff != tksr_pkg::FUNC_ENTRY) begin
         // evicting: the new entry takes the last slot; count stays full
         score_ff <= score_ff;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = st_ff;
   assign rsp_rank_before = old_ff;
   assign rsp_rank_after  = new_ff;
   assign rsp_found_id    = fid_ff;
   assign rsp_found_score = fsc_ff;

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for the top-k score ranking table
// depends on tksr_pkg and top_k_score_ranking_table
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      tksr_pkg::func_type func;
      logic [63:0]        id;
      logic [63:0]        score;
      logic [7:0]         rank;
   } cmd_type;

   typedef struct {
      tksr_pkg::status_type status;
      logic [7:0]           rank_before;
      logic [7:0]           rank_after;
      logic [63:0]          fid;
      logic [63:0]          fscore;
   } rsp_type;

   typedef struct {
      cmd_type cmd;
      bit      typed;
      rsp_type want;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_func = '0;
   logic [63:0] req_entry_id = '0;
   logic [63:0] req_score_value = '0;
   logic [7:0]  req_rank_position = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_rank_before;
   logic [7:0]  rsp_rank_after;
   logic [63:0] rsp_found_id;
   logic [63:0] rsp_found_score;

   // predictor state
   logic [63:0] board_ids[tksr_pkg::Entries];
   logic [63:0] board_scores[tksr_pkg::Entries];
   int          board_count = 0;
   rsp_type     pending_rsp[$];
   int          errors = 0;
   logic [63:0] id_pool[16];

   always #5 clock = ~clock;

   top_k_score_ranking_table i_dut (.*);

   function automatic int find_slot(logic [63:0] id);
      for (int i = 0; i < board_count; i++)
         if (board_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [63:0] t;
      t = board_ids[a]; board_ids[a] = board_ids[b]; board_ids[b] = t;
      t = board_scores[a]; board_scores[a] = board_scores[b]; board_scores[b] = t;
   endfunction

   function automatic int settle(int pos);
      while (pos > 0 && $signed(board_scores[pos]) > $signed(board_scores[pos-1])) begin
         swap_slots(pos, pos - 1);
         pos--;
      end
      while (pos + 1 < board_count
             && $signed(board_scores[pos+1]) > $signed(board_scores[pos])) begin
         swap_slots(pos, pos + 1);
         pos++;
      end
      return pos;
   endfunction

   function automatic rsp_type rank_board(cmd_type c);
      rsp_type r;
      int      s;
      r = '{tksr_pkg::ST_OK, 8'd0, 8'd0, 64'd0, 64'd0};
      case (c.func)
         tksr_pkg::FUNC_UPDATE: begin
            s = find_slot(c.id);
            if (s >= 0) begin
               r.rank_before = 8'(s + 1);
               board_scores[s] = c.score;
               r.rank_after = 8'(settle(s) + 1);
            end else if (board_count >= tksr_pkg::Entries
                         && !($signed(c.score)
                              > $signed(board_scores[tksr_pkg::Entries-1]))) begin
               r.status = tksr_pkg::ST_NOT_PLACE;
            end else begin
               if (board_count >= tksr_pkg::Entries) board_count = tksr_pkg::Entries - 1;
               board_ids[board_count] = c.id;
               board_scores[board_count] = c.score;
               board_count++;
               r.rank_after = 8'(settle(board_count - 1) + 1);
            end
         end
         tksr_pkg::FUNC_REMOVE: begin
            s = find_slot(c.id);
            if (s < 0) r.status = tksr_pkg::ST_ABSENT;
            else begin
               r.rank_before = 8'(s + 1);
               for (int i = s + 1; i < board_count; i++) begin
                  board_ids[i-1] = board_ids[i];
                  board_scores[i-1] = board_scores[i];
               end
               board_count--;
            end
         end
         tksr_pkg::FUNC_RANK: begin
            s = find_slot(c.id);
            if (s < 0) r.status = tksr_pkg::ST_ABSENT;
            else r.rank_after = 8'(s + 1);
         end
         default: begin
            if (c.rank == 0 || c.rank > board_count) r.status = tksr_pkg::ST_BAD_RANK;
            else begin
               r.fid = board_ids[c.rank-1];
               r.fscore = board_scores[c.rank-1];
            end
         end
      endcase
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // results are accepted at the edge that ends the strobe cycle
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) report("unexpected word", 64'd0, 64'd0);
         else begin
            w = pending_rsp.pop_front();
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
            if (rsp_rank_before !== w.rank_before)
               report("rank_before", rsp_rank_before, w.rank_before);
            if (rsp_rank_after !== w.rank_after)
               report("rank_after", rsp_rank_after, w.rank_after);
            if (rsp_found_id !== w.fid) report("found_id", rsp_found_id, w.fid);
            if (rsp_found_score !== w.fscore)
               report("found_score", rsp_found_score, w.fscore);
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(posedge clock);
   endtask

   // hold start until the block takes the word
   task automatic issue(cmd_type c, bit typed, rsp_type want);
      rsp_type p;
      req_func <= c.func;
      req_entry_id <= c.id;
      req_score_value <= c.score;
      req_rank_position <= c.rank;
      start <= 1;
      do @(posedge clock); while (busy);
      p = rank_board(c);
      if (typed && p != want) report("table row", 64'(p.status), 64'(want.status));
      pending_rsp.push_back(p);
      start <= 0;
      // the block is busy after the accepting edge
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_score();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return rand64();
         default: return 64'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   function automatic cmd_type random_cmd(int fill_bias);
      cmd_type c;
      int      k;
      k = $urandom_range(0, 99);
      c.func  = k < fill_bias ? tksr_pkg::FUNC_UPDATE
                : tksr_pkg::func_type'($urandom_range(0, 3));
      c.id    = ($urandom_range(0, 9) == 0) ? rand64()
                : (board_count > 0 && $urandom_range(0, 1)) ?
                  board_ids[$urandom_range(0, board_count - 1)]
                : id_pool[$urandom_range(0, 15)] + 64'($urandom_range(0, 200));
      c.score = pick_score();
      c.rank  = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 130));
      return c;
   endfunction

   initial begin
      #2_000_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      row_type     rows[$];
      cmd_type     c;
      rsp_type     none;
      logic [63:0] mx, mn;
      int          t;
      mx = 64'h7fff_ffff_ffff_ffff;
      mn = 64'h8000_0000_0000_0000;
      none = '{tksr_pkg::ST_OK, 8'd0, 8'd0, 64'd0, 64'd0};
      for (int i = 0; i < 16; i++) id_pool[i] = rand64();
      id_pool[0] = 64'd0;
      id_pool[1] = 64'hffff_ffff_ffff_ff00;
      rows = '{
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'd1}, 1,
           '{tksr_pkg::ST_BAD_RANK, 8'd0, 8'd0, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_RANK, 64'd5, 64'd0, 8'd0}, 1,
           '{tksr_pkg::ST_ABSENT, 8'd0, 8'd0, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_REMOVE, 64'd5, 64'd0, 8'd0}, 1,
           '{tksr_pkg::ST_ABSENT, 8'd0, 8'd0, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_UPDATE, 64'd0, mn, 8'd0}, 1,
           '{tksr_pkg::ST_OK, 8'd0, 8'd1, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_UPDATE, '1, mx, 8'hff}, 1,
           '{tksr_pkg::ST_OK, 8'd0, 8'd1, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'd1}, 1,
           '{tksr_pkg::ST_OK, 8'd0, 8'd0, '1, mx}},
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'd2}, 1,
           '{tksr_pkg::ST_OK, 8'd0, 8'd0, 64'd0, mn}},
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'd0}, 1,
           '{tksr_pkg::ST_BAD_RANK, 8'd0, 8'd0, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'd3}, 1,
           '{tksr_pkg::ST_BAD_RANK, 8'd0, 8'd0, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'hff}, 1,
           '{tksr_pkg::ST_BAD_RANK, 8'd0, 8'd0, 64'd0, 64'd0}},
         // equal score: no move
         '{'{tksr_pkg::FUNC_UPDATE, 64'd7, mn, 8'd0}, 1,
           '{tksr_pkg::ST_OK, 8'd0, 8'd3, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_UPDATE, 64'd7, 64'd9, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_UPDATE, '1, 64'd9, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_UPDATE, '1, mn, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_RANK, '1, 64'd0, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_REMOVE, 64'd7, 64'd0, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_RANK, 64'd0, 64'd0, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_REMOVE, 64'd0, 64'd0, 8'd0}, 0, none},
         '{'{tksr_pkg::FUNC_REMOVE, '1, 64'd0, 8'd0}, 1,
           '{tksr_pkg::ST_OK, 8'd1, 8'd0, 64'd0, 64'd0}},
         '{'{tksr_pkg::FUNC_ENTRY, 64'd0, 64'd0, 8'd1}, 1,
           '{tksr_pkg::ST_BAD_RANK, 8'd0, 8'd0, 64'd0, 64'd0}}
      };
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         issue(rows[i].cmd, rows[i].typed, rows[i].want);
         idle_gap();
      end
      // fill the board to capacity, then fight over the last place
      t = 0;
      while (board_count < tksr_pkg::Entries && t < 400) begin
         c = '{tksr_pkg::FUNC_UPDATE, rand64(),
               64'($signed($urandom_range(0, 60)) - 30), 8'd0};
         issue(c, 0, none);
         if ($urandom_range(0, 15) == 0) idle_gap();
         t++;
      end
      for (int i = 0; i < 900; i++) begin
         c = random_cmd(board_count < tksr_pkg::Entries ? 45 : 20);
         issue(c, 0, none);
         if (i == 500) wait (pending_rsp.size() == 0);
         if ($urandom_range(0, 2) == 0) idle_gap();
      end
      t = 0;
      while (pending_rsp.size() != 0 && t < 100000) begin
         @(posedge clock);
         t++;
      end
      repeat (600) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
